// ===== hw/rtl/rvid_pkg.sv =====
// Shared types and constants for the RV64IM instruction decoder.
// Stands alone; every other file in hw/rtl imports it.
package rvid_pkg;

  localparam int InsnW    = 32;
  localparam int KindW    = 7;
  localparam int FmtW     = 3;
  localparam int RegW     = 5;
  localparam int ImmW     = 32;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  // Major opcodes, bits 6:0
  localparam logic [6:0] OpcLoad   = 7'b0000011;
  localparam logic [6:0] OpcMiscMem = 7'b0001111;
  localparam logic [6:0] OpcOpImm  = 7'b0010011;
  localparam logic [6:0] OpcAuipc  = 7'b0010111;
  localparam logic [6:0] OpcOpImm32 = 7'b0011011;
  localparam logic [6:0] OpcStore  = 7'b0100011;
  localparam logic [6:0] OpcOp     = 7'b0110011;
  localparam logic [6:0] OpcLui    = 7'b0110111;
  localparam logic [6:0] OpcOp32   = 7'b0111011;
  localparam logic [6:0] OpcBranch = 7'b1100011;
  localparam logic [6:0] OpcJalr   = 7'b1100111;
  localparam logic [6:0] OpcJal    = 7'b1101111;
  localparam logic [6:0] OpcSystem = 7'b1110011;

  localparam logic [6:0] Funct7Zero = 7'b0000000;
  localparam logic [6:0] Funct7Alt  = 7'b0100000;
  localparam logic [6:0] Funct7Mul  = 7'b0000001;
  localparam logic [5:0] Funct6Zero = 6'b000000;
  localparam logic [5:0] Funct6Sra  = 6'b010000;
  localparam logic [6:0] SysEcall   = 7'd0;
  localparam logic [6:0] SysEbreak  = 7'd1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgXlen64 = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgMulDiv = CfgIdxW'(1);

  typedef enum logic [KindW-1:0] {
    K_ILL, K_ADD, K_SUB, K_SLL, K_SLT, K_SLTU, K_XOR, K_SRL, K_SRA, K_OR, K_AND,
    K_JALR, K_LB, K_LH, K_LW, K_LBU, K_LHU, K_ADDI, K_SLTI, K_SLTIU, K_XORI,
    K_ORI, K_ANDI, K_SLLI, K_SRLI, K_SRAI, K_FENCE, K_ECALL, K_EBREAK,
    K_SB, K_SH, K_SW, K_BEQ, K_BNE, K_BLT, K_BGE, K_BLTU, K_BGEU,
    K_LUI, K_AUIPC, K_JAL, K_ADDW, K_SUBW, K_SLLW, K_SRLW, K_SRAW,
    K_LWU, K_LD, K_ADDIW, K_SLLIW, K_SRLIW, K_SRAIW, K_SD,
    K_MUL, K_MULH, K_MULHSU, K_MULHU, K_DIV, K_DIVU, K_REM, K_REMU,
    K_MULW, K_DIVW, K_DIVUW, K_REMW, K_REMUW
  } kind_t;

  typedef enum logic [FmtW-1:0] {
    F_NONE, F_R, F_I, F_S, F_B, F_U, F_J
  } fmt_t;

  typedef struct packed {
    logic xlen64;
    logic mul_div;
  } rvid_mode_t;

  typedef struct packed {
    kind_t                   kind;
    fmt_t                    fmt;
    logic [RegW-1:0]         rd;
    logic [RegW-1:0]         rs1;
    logic [RegW-1:0]         rs2;
    logic signed [ImmW-1:0]  imm;
  } rvid_result_t;

endpackage

// ===== hw/rtl/rvid_cfg_regs.sv =====
// Mode register file for the decoder: xlen and M-extension enables.
// Depends on rvid_pkg.
module rvid_cfg_regs
  import rvid_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output rvid_mode_t          mode
);

  rvid_mode_t mode_r, mode_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_valid) begin
      // only bit 0 counts; unknown indexes drop silently
      if (cfg_index == CfgXlen64) begin
        mode_nxt.xlen64 = cfg_data[0];
      end else if (cfg_index == CfgMulDiv) begin
        mode_nxt.mul_div = cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '{xlen64: 1'b1, mul_div: 1'b1};
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign mode = mode_r;

endmodule

// ===== hw/rtl/rvid_decode.sv =====
// Combinational decode of one instruction word into kind, format, registers
// and immediate. Depends on rvid_pkg.
module rvid_decode
  import rvid_pkg::*;
(
  input  logic [InsnW-1:0] insn,
  input  rvid_mode_t       mode,
  output rvid_result_t     res
);

  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [5:0] f6;
  kind_t      kind;
  fmt_t       fmt;
  logic       is_shamt;
  logic [ImmW-1:0] shamt;
  logic [ImmW-1:0] imm_i, imm_s, imm_b, imm_u, imm_j;

  assign opc = insn[6:0];
  assign f3  = insn[14:12];
  assign f7  = insn[31:25];
  assign f6  = insn[31:26];

  assign imm_i = {{20{insn[31]}}, insn[31:20]};
  assign imm_s = {{20{insn[31]}}, insn[31:25], insn[11:7]};
  assign imm_b = {{19{insn[31]}}, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};
  assign imm_u = {insn[31:12], 12'b0};
  assign imm_j = {{11{insn[31]}}, insn[31], insn[19:12], insn[20], insn[30:21], 1'b0};

  always_comb begin
    kind     = K_ILL;
    fmt      = F_NONE;
    is_shamt = 1'b0;
    shamt    = {27'b0, insn[24:20]};
    unique case (opc)
      OpcOp: begin
        fmt = F_R;
        if (f7 == Funct7Zero) begin
          unique case (f3)
            3'd0: kind = K_ADD;
            3'd1: kind = K_SLL;
            3'd2: kind = K_SLT;
            3'd3: kind = K_SLTU;
            3'd4: kind = K_XOR;
            3'd5: kind = K_SRL;
            3'd6: kind = K_OR;
            default: kind = K_AND;
          endcase
        end else if (f7 == Funct7Alt) begin
          kind = (f3 == 3'd0) ? K_SUB : (f3 == 3'd5) ? K_SRA : K_ILL;
        end else if (f7 == Funct7Mul && mode.mul_div) begin
          kind = kind_t'(KindW'(K_MUL) + KindW'(f3));
        end
      end
      OpcOp32: begin
        fmt = F_R;
        if (mode.xlen64) begin
          if (f7 == Funct7Zero) begin
            kind = (f3 == 3'd0) ? K_ADDW : (f3 == 3'd1) ? K_SLLW :
                   (f3 == 3'd5) ? K_SRLW : K_ILL;
          end else if (f7 == Funct7Alt) begin
            kind = (f3 == 3'd0) ? K_SUBW : (f3 == 3'd5) ? K_SRAW : K_ILL;
          end else if (f7 == Funct7Mul && mode.mul_div) begin
            unique case (f3)
              3'd0: kind = K_MULW;
              3'd4: kind = K_DIVW;
              3'd5: kind = K_DIVUW;
              3'd6: kind = K_REMW;
              3'd7: kind = K_REMUW;
              default: kind = K_ILL;
            endcase
          end
        end
      end
      OpcJalr: begin
        fmt  = F_I;
        kind = K_JALR;
      end
      OpcLoad: begin
        fmt = F_I;
        unique case (f3)
          3'd0: kind = K_LB;
          3'd1: kind = K_LH;
          3'd2: kind = K_LW;
          3'd3: kind = mode.xlen64 ? K_LD : K_ILL;
          3'd4: kind = K_LBU;
          3'd5: kind = K_LHU;
          3'd6: kind = mode.xlen64 ? K_LWU : K_ILL;
          default: kind = K_ILL;
        endcase
      end
      OpcOpImm: begin
        fmt = F_I;
        if (mode.xlen64) begin
          shamt = {26'b0, insn[25:20]};
        end
        unique case (f3)
          3'd0: kind = K_ADDI;
          3'd1: begin
            kind     = K_SLLI;
            is_shamt = 1'b1;
          end
          3'd2: kind = K_SLTI;
          3'd3: kind = K_SLTIU;
          3'd4: kind = K_XORI;
          3'd5: begin
            is_shamt = 1'b1;
            if (mode.xlen64) begin
              kind = (f6 == Funct6Zero) ? K_SRLI : (f6 == Funct6Sra) ? K_SRAI : K_ILL;
            end else begin
              kind = (f7 == Funct7Zero) ? K_SRLI : K_SRAI;
            end
          end
          3'd6: kind = K_ORI;
          default: kind = K_ANDI;
        endcase
      end
      OpcMiscMem: begin
        fmt  = F_I;
        kind = K_FENCE;
      end
      OpcSystem: begin
        fmt  = F_I;
        kind = (insn[26:20] == SysEcall) ? K_ECALL :
               (insn[26:20] == SysEbreak) ? K_EBREAK : K_ILL;
      end
      OpcOpImm32: begin
        fmt = F_I;
        if (mode.xlen64) begin
          unique case (f3)
            3'd0: kind = K_ADDIW;
            3'd1: begin
              kind     = K_SLLIW;
              is_shamt = 1'b1;
            end
            3'd5: begin
              kind     = (f7 == Funct7Zero) ? K_SRLIW : (f7 == Funct7Alt) ? K_SRAIW : K_ILL;
              is_shamt = 1'b1;
            end
            default: kind = K_ILL;
          endcase
        end
      end
      OpcStore: begin
        fmt = F_S;
        unique case (f3)
          3'd0: kind = K_SB;
          3'd1: kind = K_SH;
          3'd2: kind = K_SW;
          3'd3: kind = mode.xlen64 ? K_SD : K_ILL;
          default: kind = K_ILL;
        endcase
      end
      OpcBranch: begin
        fmt = F_B;
        unique case (f3)
          3'd0: kind = K_BEQ;
          3'd1: kind = K_BNE;
          3'd4: kind = K_BLT;
          3'd5: kind = K_BGE;
          3'd6: kind = K_BLTU;
          3'd7: kind = K_BGEU;
          default: kind = K_ILL;
        endcase
      end
      OpcLui: begin
        fmt  = F_U;
        kind = K_LUI;
      end
      OpcAuipc: begin
        fmt  = F_U;
        kind = K_AUIPC;
      end
      OpcJal: begin
        fmt  = F_J;
        kind = K_JAL;
      end
      default: begin
        kind = K_ILL;
      end
    endcase
  end

  // Pick the fields the format carries; illegal words come out all zero.
  always_comb begin
    res      = '0;
    res.kind = kind;
    if (kind != K_ILL) begin
      res.fmt = fmt;
      unique case (fmt)
        F_R: begin
          res.rd  = insn[11:7];
          res.rs1 = insn[19:15];
          res.rs2 = insn[24:20];
        end
        F_I: begin
          res.rd  = insn[11:7];
          res.rs1 = insn[19:15];
          res.imm = is_shamt ? shamt : imm_i;
        end
        F_S: begin
          res.rs1 = insn[19:15];
          res.rs2 = insn[24:20];
          res.imm = imm_s;
        end
        F_B: begin
          res.rs1 = insn[19:15];
          res.rs2 = insn[24:20];
          res.imm = imm_b;
        end
        F_U: begin
          res.rd  = insn[11:7];
          res.imm = imm_u;
        end
        F_J: begin
          res.rd  = insn[11:7];
          res.imm = imm_j;
        end
        default: begin
          res.fmt = F_NONE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/riscv_instruction_decoder.sv =====
// RV64IM instruction decoder top level: input register, decode, result register.
// Depends on rvid_pkg, rvid_cfg_regs and rvid_decode.
//
// Usage: one request (a 32-bit instruction word) in, one result out, at a
// sustained rate of one request per cycle while out_ready stays high. A
// request is captured in the input register, decoded by a single shallow
// combinational pass (opcode/funct compare plus immediate selection), and the
// result is held in the output register until the consumer takes it. out_valid
// rises when the decoded request is loaded into the result register, which
// can wait while a held result is not taken. The two registers act as a
// two-entry pipeline, so a new request is taken while a finished result waits.
// The result register's occupancy sets the rate: when out_ready stays low the
// pipe fills and in_ready drops after two requests. Mode registers
// (xlen_sixty_four at index 0, mul_div_enable at index 1, both reset to 1)
// are written through the cfg_ channel, which is always ready; only bit 0 of
// cfg_data counts and other indexes are ignored. Change modes only while the
// block is empty. Illegal or disabled encodings return kind 0 with all other
// fields zero.
module riscv_instruction_decoder
  import rvid_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [InsnW-1:0]    in_insn_word,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KindW-1:0]    out_kind,
  output logic [FmtW-1:0]     out_format_class,
  output logic [RegW-1:0]     out_dest_reg,
  output logic [RegW-1:0]     out_src_reg_one,
  output logic [RegW-1:0]     out_src_reg_two,
  output logic signed [ImmW-1:0] out_immediate,
  // configuration channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  rvid_mode_t   mode;
  rvid_result_t dec_res;

  logic             s1_valid_r, s1_valid_nxt;
  logic [InsnW-1:0] s1_insn_r;
  logic             s2_valid_r, s2_valid_nxt;
  rvid_result_t     s2_res_r;
  logic             s2_load;
  logic             in_fire;

  rvid_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mode      (mode)
  );

  rvid_decode u_dec (
    .insn (s1_insn_r),
    .mode (mode),
    .res  (dec_res)
  );

  // Result register frees up when empty or when its request is taken this cycle.
  assign s2_load  = s1_valid_r && (!s2_valid_r || out_ready);
  // Input register takes a new request when empty or when it advances.
  assign in_ready = !s1_valid_r || s2_load;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_load) begin
      s1_valid_nxt = 1'b0;
    end

    s2_valid_nxt = s2_valid_r;
    if (s2_load) begin
      s2_valid_nxt = 1'b1;
    end else if (out_ready) begin
      s2_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // Payload registers: capture on advance, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_insn_r <= in_insn_word;
    end
    if (s2_load) begin
      s2_res_r <= dec_res;
    end
  end

  assign out_valid        = s2_valid_r;
  assign out_kind         = s2_res_r.kind;
  assign out_format_class = s2_res_r.fmt;
  assign out_dest_reg     = s2_res_r.rd;
  assign out_src_reg_one  = s2_res_r.rs1;
  assign out_src_reg_two  = s2_res_r.rs2;
  assign out_immediate    = s2_res_r.imm;

endmodule
